/* hdl/arh_pkg.sv */
// Shared types and constants for the airflow relay hysteresis block.
package arh_pkg;

  // Fixed field widths
  localparam int RawW    = 16;
  localparam int ThrW    = 12;
  localparam int DelayW  = 32;
  localparam int DeltaW  = 12;
  localparam int ApbDw   = 32;
  localparam int ApbAw   = 4;

  // Saturation limits of the reported delta
  localparam int DeltaMax = 2047;
  localparam int DeltaMin = -2048;

  // Register reset values
  localparam logic signed [ThrW-1:0] OnThrRst    = 12'sd5;
  localparam logic signed [ThrW-1:0] OffThrRst   = 12'sd1;
  localparam logic [DelayW-1:0]      OffDelayRst = 32'd60000;

  // Item kinds
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  // Register indexes (word address bits)
  typedef enum logic [1:0] {
    REG_ON_THR    = 2'd0,
    REG_OFF_THR   = 2'd1,
    REG_OFF_DELAY = 2'd2
  } reg_idx_e;

  // One result word
  typedef struct packed {
    logic                     relay_on;
    logic                     calibrated;
    logic                     fault;
    logic                     read_error;
    logic signed [DeltaW-1:0] delta_pa;
  } result_t;

endpackage

/* hdl/airflow_relay_hysteresis_top.sv */
// Airflow relay: sample scaling, baseline calibration, hysteresis with off-delay.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  in      | in        | in_valid_i / in_stall_o | operation_i, raw_sample_i, read_ok_i
//  out     | out       | out_valid_o/out_stall_i | relay_on_o, calibrated_o, fault_o,
//          |           |                        | read_error_o, delta_pa_o
//  cfg     | in        | APB psel/penable/pready | paddr, pwdata, prdata
//
// One word is taken per cycle while in_stall_o is low; each word passes the input register,
// the scaling multiply register and the relay state update into the result register.
// The relay state update closes on itself each cycle, which sets the one-word-per-cycle rate.
// Reset clears all control state and loads the register defaults; no clearing pass.
// A stall on the output backs up through the three stages; empty stages are filled first.
module airflow_relay_hysteresis_top #(
  parameter int CAL_SAMPLES   = 10,
  parameter int SCALE_DIVISOR = 60
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  arh_pkg::op_e                      operation_i,
  input  logic signed [arh_pkg::RawW-1:0]   raw_sample_i,
  input  logic                              read_ok_i,
  // Output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              relay_on_o,
  output logic                              calibrated_o,
  output logic                              fault_o,
  output logic                              read_error_o,
  output logic signed [arh_pkg::DeltaW-1:0] delta_pa_o,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [arh_pkg::ApbAw-1:0]         paddr,
  input  logic [arh_pkg::ApbDw-1:0]         pwdata,
  output logic [arh_pkg::ApbDw-1:0]         prdata,
  output logic                              pready
);
  import arh_pkg::*;

  // Derived widths: largest pascal magnitude, calibration sum and counter
  localparam int PaMax  = 32768 / SCALE_DIVISOR;
  localparam int PaW    = $clog2(PaMax + 1) + 1;
  localparam int SumW   = $clog2(PaMax * CAL_SAMPLES + 1) + 1;
  localparam int CntW   = $clog2(CAL_SAMPLES + 1);
  localparam int DiffW  = (PaW + 1 > DeltaW + 1) ? PaW + 1 : DeltaW + 1;

  // Reciprocal for the sample scaling: exact for magnitudes below 2^RawW
  localparam int                SclShift = RawW + $clog2(SCALE_DIVISOR);
  localparam longint unsigned   SclRecipL =
    ((64'd1 << SclShift) + SCALE_DIVISOR - 1) / SCALE_DIVISOR;
  localparam logic [SclShift:0] SclRecip = SclRecipL[SclShift:0];
  localparam int                SclPw    = RawW + SclShift + 1;

  // Reciprocal for the baseline average: exact for magnitudes below 2^SumW
  localparam int                AvgShift = SumW + $clog2(CAL_SAMPLES);
  localparam longint unsigned   AvgRecipL =
    ((64'd1 << AvgShift) + CAL_SAMPLES - 1) / CAL_SAMPLES;
  localparam logic [AvgShift:0] AvgRecip = AvgRecipL[AvgShift:0];
  localparam int                AvgPw    = SumW + AvgShift + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [ThrW-1:0] on_thr_q, off_thr_q;
  logic [DelayW-1:0]      off_delay_q;
  logic                   cfg_wr;
  reg_idx_e               cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  // Write the addressed register; ignore unused addresses
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_thr_q    <= OnThrRst;
      off_thr_q   <= OffThrRst;
      off_delay_q <= OffDelayRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ON_THR:    on_thr_q    <= pwdata[ThrW-1:0];
        REG_OFF_THR:   off_thr_q   <= pwdata[ThrW-1:0];
        REG_OFF_DELAY: off_delay_q <= pwdata[DelayW-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    unique case (cfg_idx)
      REG_ON_THR:    prdata = ApbDw'(on_thr_q);
      REG_OFF_THR:   prdata = ApbDw'(off_thr_q);
      REG_OFF_DELAY: prdata = ApbDw'(off_delay_q);
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control
  // ---------------------------------------------------------------------------
  logic in_valid_q, pa_valid_q, out_valid_q;
  logic out_free, pa_free, in_free;
  logic in_accept, in_move, pa_move;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign pa_move    = pa_valid_q && out_free;
  assign pa_free    = !pa_valid_q || out_free;
  assign in_move    = in_valid_q && pa_free;
  assign in_free    = !in_valid_q || pa_free;
  assign in_stall_o = !in_free;
  assign in_accept  = in_valid_i && in_free;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      pa_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_accept || (in_valid_q && !in_move);
      pa_valid_q  <= in_move || (pa_valid_q && !pa_move);
      out_valid_q <= pa_move || (out_valid_q && out_stall_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------------
  op_e                    in_op_q;
  logic signed [RawW-1:0] in_raw_q;
  logic                   in_ok_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_op_q  <= operation_i;
      in_raw_q <= raw_sample_i;
      in_ok_q  <= read_ok_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: scale raw word to pascals, truncating toward zero
  // ---------------------------------------------------------------------------
  logic                  raw_neg;
  logic [RawW-1:0]       raw_mag;
  logic [SclPw-1:0]      scl_prod;
  logic [RawW-1:0]       scl_quo;
  logic signed [PaW-1:0] pa_scaled;

  always_comb begin
    raw_neg   = in_raw_q[RawW-1];
    raw_mag   = raw_neg ? RawW'(-in_raw_q) : RawW'(in_raw_q);
    scl_prod  = SclPw'(raw_mag) * SclPw'(SclRecip);
    scl_quo   = scl_prod[SclShift +: RawW];
    pa_scaled = raw_neg ? -$signed(PaW'(scl_quo)) : $signed(PaW'(scl_quo));
  end

  op_e                   pa_op_q;
  logic signed [PaW-1:0] pa_val_q;
  logic                  pa_ok_q;

  always_ff @(posedge clk_i) begin
    if (in_move) begin
      pa_op_q  <= in_op_q;
      pa_val_q <= pa_scaled;
      pa_ok_q  <= in_ok_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: calibration and relay state
  // ---------------------------------------------------------------------------
  logic                   relay_q, relay_d;
  logic                   timing_q, timing_d;
  logic [DelayW-1:0]      low_q, low_d;
  logic signed [PaW-1:0]  base_q, base_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   done_q, done_d;
  logic                   fault_q, fault_d;

  logic signed [SumW-1:0]  sum_next;
  logic [CntW-1:0]         cnt_next;
  logic                    sum_neg;
  logic [SumW-1:0]         sum_mag;
  logic [AvgPw-1:0]        avg_prod;
  logic [PaW-1:0]          avg_quo;
  logic signed [PaW-1:0]   base_avg;
  logic signed [DiffW-1:0] diff_w, diff_sat;
  logic signed [DeltaW-1:0] delta;
  logic                    rd_err;
  logic signed [DeltaW-1:0] delta_res;

  // Form the running sum and its average for the last calibration sample
  always_comb begin
    sum_next = sum_q + SumW'(pa_val_q);
    cnt_next = cnt_q + 1'b1;
    sum_neg  = sum_next[SumW-1];
    sum_mag  = sum_neg ? SumW'(-sum_next) : SumW'(sum_next);
    avg_prod = AvgPw'(sum_mag) * AvgPw'(AvgRecip);
    avg_quo  = avg_prod[AvgShift +: PaW];
    base_avg = sum_neg ? -$signed(avg_quo) : $signed(avg_quo);
  end

  // Take the difference from the baseline and clamp it to the delta range
  always_comb begin
    diff_w = DiffW'(pa_val_q) - DiffW'(base_q);
    if (diff_w > DiffW'(DeltaMax)) begin
      diff_sat = DiffW'(DeltaMax);
    end else if (diff_w < DiffW'(DeltaMin)) begin
      diff_sat = DiffW'(DeltaMin);
    end else begin
      diff_sat = diff_w;
    end
    delta = $signed(diff_sat[DeltaW-1:0]);
  end

  // Update state for the word leaving stage 2
  always_comb begin
    relay_d   = relay_q;
    timing_d  = timing_q;
    low_d     = low_q;
    base_d    = base_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    done_d    = done_q;
    fault_d   = fault_q;
    rd_err    = 1'b0;
    delta_res = '0;
    if (pa_move) begin
      unique case (pa_op_q)
        OP_TICK: begin
          // Count low time, holding at the top
          if (timing_q && (low_q != '1)) begin
            low_d = low_q + 1'b1;
          end
        end
        OP_SAMPLE: begin
          priority if (!pa_ok_q) begin
            rd_err = 1'b1;
            if (!done_q) begin
              fault_d = 1'b1;
            end
          end else if (!done_q) begin
            if (!fault_q) begin
              sum_d = sum_next;
              cnt_d = cnt_next;
              if (cnt_next >= CntW'(CAL_SAMPLES)) begin
                base_d = base_avg;
                done_d = 1'b1;
              end
            end
          end else begin
            delta_res = delta;
            priority if (!relay_q) begin
              if (delta >= on_thr_q) begin
                relay_d  = 1'b1;
                timing_d = 1'b0;
                low_d    = '0;
              end
            end else if (delta < off_thr_q) begin
              priority if (!timing_q) begin
                timing_d = 1'b1;
                low_d    = '0;
              end else if (low_q >= off_delay_q) begin
                relay_d  = 1'b0;
                timing_d = 1'b0;
                low_d    = '0;
              end
            end else begin
              timing_d = 1'b0;
              low_d    = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Hold the block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relay_q  <= 1'b0;
      timing_q <= 1'b0;
      low_q    <= '0;
      base_q   <= '0;
      sum_q    <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      fault_q  <= 1'b0;
    end else begin
      relay_q  <= relay_d;
      timing_q <= timing_d;
      low_q    <= low_d;
      base_q   <= base_d;
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
      fault_q  <= fault_d;
    end
  end

  // Result register
  result_t out_res_q;

  always_ff @(posedge clk_i) begin
    if (pa_move) begin
      out_res_q.relay_on   <= relay_d;
      out_res_q.calibrated <= done_d;
      out_res_q.fault      <= fault_d;
      out_res_q.read_error <= rd_err;
      out_res_q.delta_pa   <= delta_res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign relay_on_o   = out_res_q.relay_on;
  assign calibrated_o = out_res_q.calibrated;
  assign fault_o      = out_res_q.fault;
  assign read_error_o = out_res_q.read_error;
  assign delta_pa_o   = out_res_q.delta_pa;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The relay can only be driven after the baseline is formed
  a_relay_needs_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    relay_q |-> done_q)
    else $error("relay on before calibration");

  // Off-delay timing runs only while the relay is on
  a_timing_needs_relay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    timing_q |-> relay_q)
    else $error("off-delay timing with relay off");

  // A fault during calibration freezes calibration until reset
  a_fault_freezes_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fault_q && !done_q) |=> (fault_q && !done_q))
    else $error("calibration advanced after fault");

  // Input backs up only when every stage is full and the output is stalled
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && pa_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

  // A failed read reports no delta
  a_err_zero_delta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && read_error_o) |-> (delta_pa_o == '0))
    else $error("nonzero delta on failed read");

endmodule
